### sv/ipv4hc_pkg.sv
// ----------------------------------------------------------------------------
// ipv4hc_pkg
// Types and constants shared by the IPv4 header check / TTL update unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4hc_pkg;

    localparam int unsigned WORD_W      = 16;
    localparam int unsigned LANE_SUM_W  = WORD_W + 1;
    localparam int unsigned LANE_COUNT  = 4;
    localparam int unsigned ACC_W       = 20;

    localparam logic [WORD_W-1:0] HDR_MIN_BYTES   = 16'd20;
    localparam logic [3:0]        HDR_MIN_WORDS   = 4'd5;
    localparam logic [3:0]        IP_VERSION_FOUR = 4'd4;

    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_TOO_SHORT = 3'd1;
    localparam logic [2:0] ERR_IHL       = 3'd2;
    localparam logic [2:0] ERR_VERSION   = 3'd3;
    localparam logic [2:0] ERR_CHECKSUM  = 3'd4;

    typedef struct packed {
        logic [15:0] word_ver_ihl_tos;
        logic [15:0] word_total_length;
        logic [15:0] word_ident;
        logic [15:0] word_flags_frag;
        logic [15:0] word_ttl_proto;
        logic [15:0] word_stored_sum;
        logic [15:0] word_src_high;
        logic [15:0] word_src_low;
        logic [15:0] word_dst_high;
        logic [15:0] word_dst_low;
        logic [15:0] buffer_bytes;
        logic [7:0]  ttl_decrement;
    } in_t;

    typedef struct packed {
        logic        header_ok;
        logic [2:0]  error_code;
        logic [15:0] computed_sum;
        logic [7:0]  new_ttl;
        logic [15:0] new_sum;
        logic [3:0]  header_words;
        logic [7:0]  protocol_number;
    } out_t;

    // What the lane stage hands to the merge stage
    typedef struct packed {
        logic [LANE_COUNT-1:0][LANE_SUM_W-1:0] lane_sum;
        logic [15:0] ttl_word;
        logic [15:0] ttl_word_next;
        logic [15:0] stored_sum;
        logic        too_short;
        logic [3:0]  ihl;
        logic [3:0]  version;
        logic [7:0]  ttl_next;
    } stage_t;

    // End-around carry fold of a wide sum, then complement
    function automatic logic [WORD_W-1:0] fold_csum(input logic [ACC_W-1:0] acc);
        logic [WORD_W:0] f1;
        logic [WORD_W:0] f2;
        f1 = {1'b0, acc[WORD_W-1:0]} + {{(WORD_W+1-(ACC_W-WORD_W)){1'b0}}, acc[ACC_W-1:WORD_W]};
        f2 = {1'b0, f1[WORD_W-1:0]} + {{WORD_W{1'b0}}, f1[WORD_W]};
        return ~f2[WORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

### sv/ipv4hc_lane.sv
// ----------------------------------------------------------------------------
// ipv4hc_lane
// One summing lane: adds a pair of header words, keeping the carry.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4hc_lane (
    input  wire logic [ipv4hc_pkg::WORD_W-1:0]     word_a,
    input  wire logic [ipv4hc_pkg::WORD_W-1:0]     word_b,
    output logic      [ipv4hc_pkg::LANE_SUM_W-1:0] pair_sum
);

    assign pair_sum = {1'b0, word_a} + {1'b0, word_b};

endmodule

`default_nettype wire

### sv/ipv4hc_merge.sv
// ----------------------------------------------------------------------------
// ipv4hc_merge
// Merges the lane sums into the old and new checksums and picks the error.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4hc_merge (
    input  wire ipv4hc_pkg::stage_t stage,
    input  wire logic [7:0]         protocol,
    output ipv4hc_pkg::out_t        result
);

    logic [ipv4hc_pkg::ACC_W-1:0] base_sum;
    logic [ipv4hc_pkg::ACC_W-1:0] acc_now;
    logic [ipv4hc_pkg::ACC_W-1:0] acc_next;
    logic [15:0]                  sum_now;
    logic [2:0]                   err;

    always_comb begin
        base_sum = '0;
        for (int i = 0; i < ipv4hc_pkg::LANE_COUNT; i++) begin
            base_sum = base_sum + ipv4hc_pkg::ACC_W'(stage.lane_sum[i]);
        end
    end

    // Only the TTL word differs between the two sums
    assign acc_now  = base_sum + ipv4hc_pkg::ACC_W'(stage.ttl_word);
    assign acc_next = base_sum + ipv4hc_pkg::ACC_W'(stage.ttl_word_next);
    assign sum_now  = ipv4hc_pkg::fold_csum(acc_now);

    always_comb begin
        if (stage.too_short) begin
            err = ipv4hc_pkg::ERR_TOO_SHORT;
        end else if (stage.ihl < ipv4hc_pkg::HDR_MIN_WORDS) begin
            err = ipv4hc_pkg::ERR_IHL;
        end else if (stage.version != ipv4hc_pkg::IP_VERSION_FOUR) begin
            err = ipv4hc_pkg::ERR_VERSION;
        end else if (stage.stored_sum != sum_now) begin
            err = ipv4hc_pkg::ERR_CHECKSUM;
        end else begin
            err = ipv4hc_pkg::ERR_OK;
        end
    end

    always_comb begin
        result.header_ok       = (err == ipv4hc_pkg::ERR_OK);
        result.error_code      = err;
        result.computed_sum    = sum_now;
        result.new_ttl         = stage.ttl_next;
        result.new_sum         = ipv4hc_pkg::fold_csum(acc_next);
        result.header_words    = stage.ihl;
        result.protocol_number = protocol;
    end

endmodule

`default_nettype wire

### sv/ipv4_header_check_ttl_update_unit.sv
// ----------------------------------------------------------------------------
// ipv4_header_check_ttl_update_unit
// IPv4 header validation with saturating TTL decrement and checksum update.
// ----------------------------------------------------------------------------
// Takes one 20-byte IPv4 header per beat and returns one result beat per
// header via the stage and output registers. A new header can be taken
// every cycle while s_ready is high: four adder lanes sum word pairs in the
// first register stage, and the merge stage folds those into the stored-sum
// check and the checksum for the rewritten TTL in the second. Ready passes
// back through both stages, so a stall on m_ready holds at most two headers
// in flight. Checks are reported by priority: short buffer, header length,
// version, checksum. Options past 20 bytes are not summed.
`default_nettype none

module ipv4_header_check_ttl_update_unit (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire ipv4hc_pkg::in_t   s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output ipv4hc_pkg::out_t       m_data
);

    logic [ipv4hc_pkg::LANE_COUNT-1:0][ipv4hc_pkg::WORD_W-1:0] lane_a;
    logic [ipv4hc_pkg::LANE_COUNT-1:0][ipv4hc_pkg::WORD_W-1:0] lane_b;
    logic [ipv4hc_pkg::LANE_COUNT-1:0][ipv4hc_pkg::LANE_SUM_W-1:0] lane_sum;

    ipv4hc_pkg::stage_t stage_next;
    ipv4hc_pkg::stage_t stage_reg;
    logic [7:0]         proto_reg;
    logic               stage_valid_reg;
    ipv4hc_pkg::out_t   merged;
    ipv4hc_pkg::out_t   out_reg;
    logic               out_valid_reg;
    logic               out_open;
    logic [7:0]         ttl;
    logic [7:0]         ttl_next;

    // Checksum word is left out of the sum
    assign lane_a[0] = s_data.word_ver_ihl_tos;
    assign lane_b[0] = s_data.word_total_length;
    assign lane_a[1] = s_data.word_ident;
    assign lane_b[1] = s_data.word_flags_frag;
    assign lane_a[2] = s_data.word_src_high;
    assign lane_b[2] = s_data.word_src_low;
    assign lane_a[3] = s_data.word_dst_high;
    assign lane_b[3] = s_data.word_dst_low;

    for (genvar g = 0; g < ipv4hc_pkg::LANE_COUNT; g++) begin : g_lane
        ipv4hc_lane u_lane (
            .word_a   (lane_a[g]),
            .word_b   (lane_b[g]),
            .pair_sum (lane_sum[g])
        );
    end

    assign ttl      = s_data.word_ttl_proto[15:8];
    assign ttl_next = (ttl > s_data.ttl_decrement) ? (ttl - s_data.ttl_decrement) : 8'd0;

    always_comb begin
        stage_next.lane_sum      = lane_sum;
        stage_next.ttl_word      = s_data.word_ttl_proto;
        stage_next.ttl_word_next = {ttl_next, s_data.word_ttl_proto[7:0]};
        stage_next.stored_sum    = s_data.word_stored_sum;
        stage_next.too_short     = (s_data.buffer_bytes < ipv4hc_pkg::HDR_MIN_BYTES)
                                || (s_data.buffer_bytes < s_data.word_total_length);
        stage_next.ihl           = s_data.word_ver_ihl_tos[11:8];
        stage_next.version       = s_data.word_ver_ihl_tos[15:12];
        stage_next.ttl_next      = ttl_next;
    end

    ipv4hc_merge u_merge (
        .stage    (stage_reg),
        .protocol (proto_reg),
        .result   (merged)
    );

    assign out_open = !out_valid_reg || m_ready;
    assign s_ready  = !stage_valid_reg || out_open;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (s_ready) begin
                stage_valid_reg <= s_valid;
            end
            if (out_open) begin
                out_valid_reg <= stage_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            stage_reg <= stage_next;
            proto_reg <= s_data.word_ttl_proto[7:0];
        end
        if (out_open && stage_valid_reg) begin
            out_reg <= merged;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_ok_matches_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.header_ok == (m_data.error_code == ipv4hc_pkg::ERR_OK)))
        else $error("header_ok disagrees with error_code");

    a_full_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_valid_reg && m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while both stages are held");

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat shown right after reset");

    a_stage_moves_on: assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_valid_reg && !m_valid) |=> m_valid)
        else $error("header in lane stage not passed to output");

endmodule

`default_nettype wire
